>>> rtl/csi_pkg.sv
// Shared constants, types and helper functions for the cubic segment interpolator.
`timescale 1ns / 1ps
`default_nettype none

package csi_pkg;

    localparam int CSI_FRAC_BITS = 16;
    localparam int CSI_NUM_W     = 131;
    localparam int CSI_DEN_W     = 96;
    localparam int CSI_QUO_W     = 42;
    localparam int CSI_MAG_W     = 41;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [CSI_MAG_W-1:0] MAG_CAP = CSI_MAG_W'(1) << (CSI_MAG_W - 1);

    typedef struct packed {
        logic [2:0]         neg;
        logic signed [31:0] vs;
        logic               dz;
    } t_side;

    // round floor(2n/d) to nearest, clamp magnitude, apply sign
    function automatic logic signed [CSI_MAG_W:0] f_round(
        input logic [CSI_QUO_W-1:0] q2,
        input logic                 ovf,
        input logic                 neg
    );
        logic [CSI_QUO_W:0]   rnd;
        logic [CSI_MAG_W-1:0] mag;
        logic [CSI_MAG_W:0]   m;
        rnd = ({1'b0, q2} + (CSI_QUO_W+1)'(1)) >> 1;
        if (ovf || rnd > (CSI_QUO_W+1)'(MAG_CAP)) begin
            mag = MAG_CAP;
        end else begin
            mag = rnd[CSI_MAG_W-1:0];
        end
        m = {1'b0, mag};
        return neg ? $signed(~m + (CSI_MAG_W+1)'(1)) : $signed(m);
    endfunction

    // {saturated, value}
    function automatic logic [32:0] f_sat32(input logic signed [CSI_MAG_W+1:0] v);
        localparam logic signed [CSI_MAG_W+1:0] VMAX = (CSI_MAG_W+2)'(32'sh7fffffff);
        localparam logic signed [CSI_MAG_W+1:0] VMIN = -(CSI_MAG_W+2)'(33'sh080000000);
        if (v > VMAX) begin
            return {1'b1, 32'h7fffffff};
        end else if (v < VMIN) begin
            return {1'b1, 32'h80000000};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/cubic_segment_interpolator.sv
// Cubic segment interpolator: zero-end-slope Hermite blend with slope and curvature.
//
// Usage: one transfer on the slave stream carries a sample time and a segment
// (start/end times and values); one transfer on the master stream returns
// level, slope, curvature and status for it. Items are independent.
// Throughput: one item per cycle while the output is not stalled. The pipeline
// has 6 stages of differences and products, 43 stages of the
// bit-per-stage dividers and 2 stages of rounding and saturation.
// The whole pipeline advances together; when the receiver holds tready low
// with a result waiting, every stage holds and tready on the slave side drops,
// so nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Reset (synchronous, active low) clears all valid bits; data registers keep
// whatever they hold. An empty segment gives zero outputs with status 1; a
// clamped result gives status 2.
`timescale 1ns / 1ps
`default_nettype none

module cubic_segment_interpolator #(
    parameter int FRAC_BITS = csi_pkg::CSI_FRAC_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // t_now, t_end, t_start, value_end, value_start
    input  wire logic [159:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // level, slope, curvature, status, zero pad
    output logic [103:0]      o_m_axis_tdata
);
    import csi_pkg::*;

    localparam int NW = CSI_NUM_W;
    localparam int DW = CSI_DEN_W;
    localparam int QW = CSI_QUO_W;
    localparam int MW = CSI_MAG_W;

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 1: differences, magnitudes, signs
    logic signed [33:0] tn, te, ts, ve, vs, u, w, d, dh;
    logic signed [35:0] k1;
    logic signed [34:0] k3;
    logic [33:0] au_f, aw_f, ad_f, adh_f;
    logic [35:0] ak1_f;
    logic [34:0] ak3_f;
    t_side       sd_f;

    assign tn = $signed({2'b00, i_s_axis_tdata[31:0]});
    assign te = $signed({2'b00, i_s_axis_tdata[63:32]});
    assign ts = $signed({2'b00, i_s_axis_tdata[95:64]});
    assign ve = 34'(signed'(i_s_axis_tdata[127:96]));
    assign vs = 34'(signed'(i_s_axis_tdata[159:128]));
    assign u  = tn - ts;
    assign w  = te - tn;
    assign d  = te - ts;
    assign dh = ve - vs;
    assign k1 = 36'(w) * 36'sd2 + 36'(d);
    assign k3 = 35'(w) - 35'(u);
    assign au_f  = u[33]  ? -u  : u;
    assign aw_f  = w[33]  ? -w  : w;
    assign ad_f  = d[33]  ? -d  : d;
    assign adh_f = dh[33] ? -dh : dh;
    assign ak1_f = k1[35] ? -k1 : k1;
    assign ak3_f = k3[34] ? -k3 : k3;
    assign sd_f  = '{neg: {dh[33] ^ k3[34] ^ d[33],
                           dh[33] ^ u[33] ^ w[33] ^ d[33],
                           dh[33] ^ k1[35] ^ d[33]},
                     vs:  signed'(i_s_axis_tdata[159:128]),
                     dz:  d == 34'sd0};

    logic        r1_v;
    logic [31:0] r1_ad, r1_adh, r1_au, r1_aw;
    logic [33:0] r1_ak1;
    logic [32:0] r1_ak3;
    t_side       r1_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ad  <= ad_f[31:0];
            r1_adh <= adh_f[31:0];
            r1_au  <= au_f[31:0];
            r1_aw  <= aw_f[31:0];
            r1_ak1 <= ak1_f[33:0];
            r1_ak3 <= ak3_f[32:0];
            r1_sd  <= sd_f;
        end
    end

    // stage 2: first products
    logic        r2_v;
    logic [63:0] r2_dd, r2_p;
    logic [64:0] r2_c;
    logic [31:0] r2_ad, r2_au, r2_aw;
    logic [33:0] r2_ak1;
    t_side       r2_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dd  <= 64'(r1_ad) * 64'(r1_ad);
            r2_p   <= 64'(r1_adh) * 64'(r1_au);
            r2_c   <= 65'(r1_adh) * 65'(r1_ak3);
            r2_ad  <= r1_ad;
            r2_au  <= r1_au;
            r2_aw  <= r1_aw;
            r2_ak1 <= r1_ak1;
            r2_sd  <= r1_sd;
        end
    end

    // stage 3: partial products of 64 by 32
    logic        r3_v;
    logic [63:0] r3_ddl, r3_ddh, r3_pul, r3_puh, r3_pwl, r3_pwh;
    logic [67:0] r3_c6;
    logic [33:0] r3_ak1;
    t_side       r3_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ddl <= 64'(r2_dd[31:0])  * 64'(r2_ad);
            r3_ddh <= 64'(r2_dd[63:32]) * 64'(r2_ad);
            r3_pul <= 64'(r2_p[31:0])   * 64'(r2_au);
            r3_puh <= 64'(r2_p[63:32])  * 64'(r2_au);
            r3_pwl <= 64'(r2_p[31:0])   * 64'(r2_aw);
            r3_pwh <= 64'(r2_p[63:32])  * 64'(r2_aw);
            r3_c6  <= (68'(r2_c) << 2) + (68'(r2_c) << 1);
            r3_ak1 <= r2_ak1;
            r3_sd  <= r2_sd;
        end
    end

    // stage 4: sum partials
    logic        r4_v;
    logic [95:0] r4_den, r4_pu, r4_pw;
    logic [67:0] r4_c6;
    logic [33:0] r4_ak1;
    t_side       r4_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_den <= (96'(r3_ddh) << 32) + 96'(r3_ddl);
            r4_pu  <= (96'(r3_puh) << 32) + 96'(r3_pul);
            r4_pw  <= (96'(r3_pwh) << 32) + 96'(r3_pwl);
            r4_c6  <= r3_c6;
            r4_ak1 <= r3_ak1;
            r4_sd  <= r3_sd;
        end
    end

    // stage 5: partial products of 96 by 34
    logic        r5_v;
    logic [65:0] r5_l0, r5_l1, r5_l2;
    logic [98:0] r5_s6;
    logic [95:0] r5_den;
    logic [67:0] r5_c6;
    t_side       r5_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_l0  <= 66'(r4_pu[31:0])  * 66'(r4_ak1);
            r5_l1  <= 66'(r4_pu[63:32]) * 66'(r4_ak1);
            r5_l2  <= 66'(r4_pu[95:64]) * 66'(r4_ak1);
            r5_s6  <= (99'(r4_pw) << 2) + (99'(r4_pw) << 1);
            r5_den <= r4_den[95:0];
            r5_c6  <= r4_c6;
            r5_sd  <= r4_sd;
        end
    end

    // stage 6: numerators
    logic          r6_v;
    logic [NW-1:0] r6_nl, r6_ns, r6_nc;
    logic [DW-1:0] r6_den;
    t_side         r6_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_nl  <= NW'(r5_l0) + (NW'(r5_l1) << 32) + (NW'(r5_l2) << 64);
            r6_ns  <= NW'(r5_s6) << FRAC_BITS;
            r6_nc  <= NW'(r5_c6) << (2 * FRAC_BITS);
            r6_den <= r5_den;
            r6_sd  <= r5_sd;
        end
    end

    // dividers
    logic [QW-1:0] q_l, q_s, q_c;
    logic          ov_l, ov_s, ov_c;

    csi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_l (
        .i_clk(i_clk), .i_en(en), .i_num(r6_nl), .i_den(r6_den), .o_quo(q_l), .o_ovf(ov_l)
    );
    csi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_s (
        .i_clk(i_clk), .i_en(en), .i_num(r6_ns), .i_den(r6_den), .o_quo(q_s), .o_ovf(ov_s)
    );
    csi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_c (
        .i_clk(i_clk), .i_en(en), .i_num(r6_nc), .i_den(r6_den), .o_quo(q_c), .o_ovf(ov_c)
    );

    logic  r_vd [0:QW];
    t_side r_sdd [0:QW];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdd[0] <= r6_sd;
            for (int i = 0; i < QW; i++) begin
                r_sdd[i+1] <= r_sdd[i];
            end
        end
    end

    // round and sign
    logic                r_rv;
    logic signed [MW:0]  r_rl, r_rs, r_rc;
    t_side               r_rsd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rl  <= f_round(q_l, ov_l, r_sdd[QW].neg[0]);
            r_rs  <= f_round(q_s, ov_s, r_sdd[QW].neg[1]);
            r_rc  <= f_round(q_c, ov_c, r_sdd[QW].neg[2]);
            r_rsd <= r_sdd[QW];
        end
    end

    // add start value, saturate
    logic [32:0] sat_l, sat_s, sat_c;
    assign sat_l = f_sat32((MW+2)'(r_rl) + (MW+2)'(r_rsd.vs));
    assign sat_s = f_sat32((MW+2)'(r_rs));
    assign sat_c = f_sat32((MW+2)'(r_rc));

    logic [31:0] r_o_lv, r_o_sl, r_o_cv;
    logic [1:0]  r_o_st;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_rsd.dz) begin
                r_o_lv <= '0;
                r_o_sl <= '0;
                r_o_cv <= '0;
                r_o_st <= ST_EMPTY;
            end else begin
                r_o_lv <= sat_l[31:0];
                r_o_sl <= sat_s[31:0];
                r_o_cv <= sat_c[31:0];
                r_o_st <= (sat_l[32] || sat_s[32] || sat_c[32]) ? ST_SAT : ST_OK;
            end
        end
    end

    // valid chain
    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
            r6_v      <= 1'b0;
            r_rv      <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i <= QW; i++) begin
                r_vd[i] <= 1'b0;
            end
        end else if (en) begin
            r1_v    <= i_s_axis_tvalid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r_vd[0] <= r6_v;
            for (int i = 0; i < QW; i++) begin
                r_vd[i+1] <= r_vd[i];
            end
            r_rv      <= r_vd[QW];
            r_o_valid <= r_rv;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {6'b0, r_o_st, r_o_cv, r_o_sl, r_o_lv};

    property p_empty_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_o_st == ST_EMPTY) |-> (o_m_axis_tdata[95:0] == 96'b0);
    endproperty
    a_empty_zero: assert property (p_empty_zero) else $error("empty segment with nonzero output");

    property p_sat_extreme;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_o_st == ST_SAT) |->
            (r_o_lv == 32'h7fffffff || r_o_lv == 32'h80000000 ||
             r_o_sl == 32'h7fffffff || r_o_sl == 32'h80000000 ||
             r_o_cv == 32'h7fffffff || r_o_cv == 32'h80000000);
    endproperty
    a_sat_extreme: assert property (p_sat_extreme) else $error("saturation flag without clamp");

    property p_stall_freeze;
        @(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r6_v) && $stable(r_rv) && $stable(r_vd[0]));
    endproperty
    a_stall_freeze: assert property (p_stall_freeze) else $error("pipeline moved during stall");

endmodule

`default_nettype wire

>>> rtl/csi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module csi_div #(
    parameter int NW = csi_pkg::CSI_NUM_W,
    parameter int DW = csi_pkg::CSI_DEN_W,
    parameter int QW = csi_pkg::CSI_QUO_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo,
    output logic               o_ovf
);
    localparam int RW = (NW + 1 > DW + QW) ? NW + 1 : DW + QW;

    logic [RW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic          r_ovf [0:QW];

    // dividend is 2*num so the last bit carries the rounding decision
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'({i_num, 1'b0});
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= RW'({i_num, 1'b0}) >= (RW'(i_den) << QW);
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;
        logic [RW-1:0] dsh;
        logic          ge;
        assign dsh = RW'(r_den[s]) << B;
        assign ge  = r_rem[s] >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= ge ? r_rem[s] - dsh : r_rem[s];
                r_den[s+1] <= r_den[s];
                r_quo[s+1] <= r_quo[s] | (QW'(ge) << B);
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

`default_nettype wire
